// ----- design/touch_edge_gesture_recognizer_top_macros.svh -----
// assertion helpers for the touch edge gesture recognizer
`ifndef TOUCH_EDGE_GESTURE_RECOGNIZER_TOP_MACROS_SVH
`define TOUCH_EDGE_GESTURE_RECOGNIZER_TOP_MACROS_SVH

// checked only outside reset
`define TEGR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define TEGR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/tegr_pkg.sv -----
package tegr_pkg;

  // field widths
  localparam int CoordW = 11;
  localparam int AmountW = 12;
  localparam int CodeW = 4;
  localparam int KindW = 3;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 12;
  localparam int InDataW = 24;
  localparam int OutDataW = 40;

  typedef logic [CoordW-1:0] coord_t;
  // wide enough for every difference and doubled difference
  typedef logic signed [13:0] sw_t;

  // event codes
  localparam logic [CodeW-1:0] EV_ACTIVITY      = 4'd0;
  localparam logic [CodeW-1:0] EV_BACK_PROGRESS = 4'd1;
  localparam logic [CodeW-1:0] EV_BACK_CANCEL   = 4'd2;
  localparam logic [CodeW-1:0] EV_BACK_COMMIT   = 4'd3;
  localparam logic [CodeW-1:0] EV_BOTTOM        = 4'd4;
  localparam logic [CodeW-1:0] EV_TOP           = 4'd5;
  localparam logic [CodeW-1:0] EV_RIGHT         = 4'd6;
  localparam logic [CodeW-1:0] EV_SWIPE_RIGHT   = 4'd7;
  localparam logic [CodeW-1:0] EV_SWIPE_LEFT    = 4'd8;
  localparam logic [CodeW-1:0] EV_DRAG          = 4'd9;
  localparam logic [CodeW-1:0] EV_FLICK         = 4'd10;

  // gesture kinds
  localparam logic [KindW-1:0] G_NONE   = 3'd0;
  localparam logic [KindW-1:0] G_BACK   = 3'd1;
  localparam logic [KindW-1:0] G_BOTTOM = 3'd2;
  localparam logic [KindW-1:0] G_TOP    = 3'd3;
  localparam logic [KindW-1:0] G_RIGHT  = 3'd4;
  localparam logic [KindW-1:0] G_SCROLL = 3'd5;

  // register indexes
  localparam logic [CfgIdxW-1:0] CFG_SCREEN_WIDTH   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_SCREEN_HEIGHT  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_EDGE_ZONE      = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_BACK_COMMIT    = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_BACK_CANCEL    = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_BACK_MAX_DY    = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_VERT_COMMIT    = 3'd6;
  localparam logic [CfgIdxW-1:0] CFG_HORIZ_COMMIT   = 3'd7;

  // motion thresholds for the scroll gesture
  localparam sw_t DragMin  = 14'sd8;
  localparam sw_t FlickMin = 14'sd20;

  typedef struct packed {
    logic [11:0]        screen_width;
    logic [11:0]        screen_height;
    logic [7:0]         edge_zone_px;
    logic [10:0]        back_commit_px;
    logic signed [11:0] back_cancel_px;
    logic [10:0]        back_max_dy;
    logic [10:0]        vertical_commit_px;
    logic [10:0]        horizontal_commit_px;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    screen_width:         12'd240,
    screen_height:        12'd240,
    edge_zone_px:         8'd28,
    back_commit_px:       11'd42,
    back_cancel_px:       -12'sd18,
    back_max_dy:          11'd120,
    vertical_commit_px:   11'd42,
    horizontal_commit_px: 11'd42
  };

  typedef struct packed {
    logic             touching;
    logic [KindW-1:0] kind;
    coord_t           start_x;
    coord_t           start_y;
  } state_t;

  typedef struct packed {
    logic [CodeW-1:0]   code;
    logic [AmountW-1:0] amount;
    coord_t             x;
    coord_t             y;
  } event_t;

  // unsigned value widened to the signed working width
  function automatic sw_t widen(input logic [11:0] v);
    widen = sw_t'({2'b00, v});
  endfunction

  function automatic sw_t absval(input sw_t v);
    absval = v[13] ? -v : v;
  endfunction

endpackage

// ----- design/touch_edge_gesture_recognizer_top.sv -----
// an accepted input word is held in the input register, then in the result register on out_tdata
// throughput: one input word per cycle while results are taken; the input register drains into the
//   result register whenever that register is empty or being taken
// a sample that yields no event still passes through and updates the gesture state
// reset (rst_n low, synchronous): both channels empty, gesture state idle,
//   configuration back to its default values
`include "touch_edge_gesture_recognizer_top_macros.svh"

module touch_edge_gesture_recognizer_top (
  input  logic                            clk,
  input  logic                            rst_n,
  // bits: contact [0], pos_x [11:1], pos_y [22:12], zero [23]
  input  logic [tegr_pkg::InDataW-1:0]    in_tdata,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // bits: event_code [3:0], amount [15:4], event_x [26:16], event_y [37:27], zero [39:38]
  output logic [tegr_pkg::OutDataW-1:0]   out_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tegr_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [tegr_pkg::CfgDataW-1:0]   cfg_data
);

  logic                 in_v_r, in_v_nxt;
  logic                 in_contact_r;
  tegr_pkg::coord_t     in_x_r, in_y_r;
  logic                 out_v_r, out_v_nxt;
  tegr_pkg::event_t     out_ev_r;
  tegr_pkg::state_t     st_r, st_nxt, step_st;
  tegr_pkg::cfg_t       cfg_r, cfg_nxt;
  tegr_pkg::event_t     step_ev;
  logic                 step_emit;
  logic                 proc;

  // input word advances when the result slot is free or being taken
  assign proc = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || proc;
  assign in_v_nxt = in_tvalid ? 1'b1 : (in_v_r && !proc);
  assign out_v_nxt = proc ? step_emit : (out_v_r && !out_tready);
  assign st_nxt = proc ? step_st : st_r;
  assign cfg_ready = 1'b1;

  tegr_step u_step (
    .contact (in_contact_r),
    .pos_x   (in_x_r),
    .pos_y   (in_y_r),
    .cfg     (cfg_r),
    .st      (st_r),
    .st_nxt  (step_st),
    .emit    (step_emit),
    .ev      (step_ev)
  );

  // configuration register write
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        tegr_pkg::CFG_SCREEN_WIDTH:  cfg_nxt.screen_width = cfg_data;
        tegr_pkg::CFG_SCREEN_HEIGHT: cfg_nxt.screen_height = cfg_data;
        tegr_pkg::CFG_EDGE_ZONE:     cfg_nxt.edge_zone_px = cfg_data[7:0];
        tegr_pkg::CFG_BACK_COMMIT:   cfg_nxt.back_commit_px = cfg_data[10:0];
        tegr_pkg::CFG_BACK_CANCEL:   cfg_nxt.back_cancel_px = cfg_data;
        tegr_pkg::CFG_BACK_MAX_DY:   cfg_nxt.back_max_dy = cfg_data[10:0];
        tegr_pkg::CFG_VERT_COMMIT:   cfg_nxt.vertical_commit_px = cfg_data[10:0];
        tegr_pkg::CFG_HORIZ_COMMIT:  cfg_nxt.horizontal_commit_px = cfg_data[10:0];
        default:                     cfg_nxt = cfg_r;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
      out_v_r <= 1'b0;
      st_r <= '0;
      cfg_r <= tegr_pkg::CfgReset;
    end else begin
      if (in_tready) begin
        in_v_r <= in_v_nxt;
      end
      out_v_r <= out_v_nxt;
      st_r <= st_nxt;
      cfg_r <= cfg_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_contact_r <= in_tdata[0];
      in_x_r <= in_tdata[11:1];
      in_y_r <= in_tdata[22:12];
    end
    if (proc && step_emit) begin
      out_ev_r <= step_ev;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata = {2'b00, out_ev_r.y, out_ev_r.x, out_ev_r.amount, out_ev_r.code};

  `TEGR_ASSERT_ALWAYS(a_out_empty_after_reset, !rst_n |=> !out_tvalid,
                      "result word valid right after reset")
  `TEGR_ASSERT(a_kind_needs_touch, (st_r.kind != tegr_pkg::G_NONE) |-> st_r.touching,
               "gesture kind set while not touching")
  `TEGR_ASSERT(a_result_from_proc, $rose(out_tvalid) |-> $past(proc),
               "result word appeared without an input word advancing")
  `TEGR_ASSERT(a_activity_touching,
               (out_tvalid && out_ev_r.code == tegr_pkg::EV_ACTIVITY) |-> st_r.touching,
               "activity word pending while contact state is released")

endmodule

// ----- design/tegr_classify.sv -----
module tegr_classify (
  input  tegr_pkg::coord_t                 pos_x,
  input  tegr_pkg::coord_t                 pos_y,
  input  tegr_pkg::cfg_t                   cfg,
  output logic [tegr_pkg::KindW-1:0]       kind
);

  tegr_pkg::sw_t sx, sy, ez, bot_lim, right_lim;

  // zone limits in exact signed arithmetic
  assign sx = tegr_pkg::widen({1'b0, pos_x});
  assign sy = tegr_pkg::widen({1'b0, pos_y});
  assign ez = tegr_pkg::widen({4'b0, cfg.edge_zone_px});
  assign bot_lim = tegr_pkg::widen(cfg.screen_height) - ez;
  assign right_lim = tegr_pkg::widen(cfg.screen_width) - ez;

  // priority: back, bottom, top, right, scroll
  always_comb begin
    if (sx <= ez) begin
      kind = tegr_pkg::G_BACK;
    end else if (sy >= bot_lim) begin
      kind = tegr_pkg::G_BOTTOM;
    end else if (sy <= ez) begin
      kind = tegr_pkg::G_TOP;
    end else if (sx >= right_lim) begin
      kind = tegr_pkg::G_RIGHT;
    end else begin
      kind = tegr_pkg::G_SCROLL;
    end
  end

endmodule

// ----- design/tegr_step.sv -----
module tegr_step (
  input  logic              contact,
  input  tegr_pkg::coord_t  pos_x,
  input  tegr_pkg::coord_t  pos_y,
  input  tegr_pkg::cfg_t    cfg,
  input  tegr_pkg::state_t  st,
  output tegr_pkg::state_t  st_nxt,
  output logic              emit,
  output tegr_pkg::event_t  ev
);

  logic [tegr_pkg::KindW-1:0] new_kind;
  tegr_pkg::sw_t dx, dy, adx, ady, ndx, ndy, am;
  tegr_pkg::sw_t bcommit, bcancel, bmaxdy, vc, hc;
  logic [tegr_pkg::CodeW-1:0] code;

  tegr_classify u_classify (
    .pos_x (pos_x),
    .pos_y (pos_y),
    .cfg   (cfg),
    .kind  (new_kind)
  );

  // travel from the start point
  assign dx = tegr_pkg::widen({1'b0, pos_x}) - tegr_pkg::widen({1'b0, st.start_x});
  assign dy = tegr_pkg::widen({1'b0, pos_y}) - tegr_pkg::widen({1'b0, st.start_y});
  assign adx = tegr_pkg::absval(dx);
  assign ady = tegr_pkg::absval(dy);
  assign ndx = -dx;
  assign ndy = -dy;
  assign bcommit = tegr_pkg::widen({1'b0, cfg.back_commit_px});
  assign bcancel = tegr_pkg::sw_t'(cfg.back_cancel_px);
  assign bmaxdy = tegr_pkg::widen({1'b0, cfg.back_max_dy});
  assign vc = tegr_pkg::widen({1'b0, cfg.vertical_commit_px});
  assign hc = tegr_pkg::widen({1'b0, cfg.horizontal_commit_px});

  // event decision and state update
  always_comb begin
    st_nxt = st;
    emit = 1'b0;
    code = tegr_pkg::EV_ACTIVITY;
    am = '0;
    if (contact && !st.touching) begin
      // touch-down: latch start and classify
      st_nxt.touching = 1'b1;
      st_nxt.start_x = pos_x;
      st_nxt.start_y = pos_y;
      st_nxt.kind = new_kind;
      emit = 1'b1;
    end else if (contact) begin
      // held contact
      if (st.kind == tegr_pkg::G_BACK) begin
        emit = 1'b1;
        if (dx <= bcancel) begin
          st_nxt.kind = tegr_pkg::G_NONE;
          code = tegr_pkg::EV_BACK_CANCEL;
        end else begin
          code = tegr_pkg::EV_BACK_PROGRESS;
          am = dx[13] ? '0 : dx;
        end
      end else if (st.kind == tegr_pkg::G_SCROLL) begin
        if (ady >= tegr_pkg::DragMin && ady >= adx) begin
          emit = 1'b1;
          code = tegr_pkg::EV_DRAG;
          am = dy;
        end
      end
    end else if (st.touching) begin
      // release: commit rules
      st_nxt.touching = 1'b0;
      st_nxt.kind = tegr_pkg::G_NONE;
      case (st.kind)
        tegr_pkg::G_BACK: begin
          emit = 1'b1;
          if (dx >= bcommit && ady <= bmaxdy && (dx <<< 1) >= ady) begin
            code = tegr_pkg::EV_BACK_COMMIT;
            am = dx;
          end else begin
            code = tegr_pkg::EV_BACK_CANCEL;
          end
        end
        tegr_pkg::G_BOTTOM: begin
          if (ndy >= vc && (ndy <<< 1) >= adx) begin
            emit = 1'b1;
            code = tegr_pkg::EV_BOTTOM;
            am = ndy;
          end
        end
        tegr_pkg::G_TOP: begin
          if (dy >= vc && (dy <<< 1) >= adx) begin
            emit = 1'b1;
            code = tegr_pkg::EV_TOP;
            am = dy;
          end
        end
        tegr_pkg::G_RIGHT: begin
          if (ndx >= hc && (ndx <<< 1) >= ady) begin
            emit = 1'b1;
            code = tegr_pkg::EV_RIGHT;
            am = ndx;
          end
        end
        tegr_pkg::G_SCROLL: begin
          if (dx >= hc && dx > ady) begin
            emit = 1'b1;
            code = tegr_pkg::EV_SWIPE_RIGHT;
            am = dx;
          end else if (ndx >= hc && ndx > ady) begin
            emit = 1'b1;
            code = tegr_pkg::EV_SWIPE_LEFT;
            am = ndx;
          end else if (ady >= tegr_pkg::FlickMin && ady > adx) begin
            emit = 1'b1;
            code = tegr_pkg::EV_FLICK;
            am = dy;
          end
        end
        default: begin
          emit = 1'b0;
        end
      endcase
    end
  end

  // travel stays within +-2047, so the low bits are exact
  assign ev.code = code;
  assign ev.amount = am[tegr_pkg::AmountW-1:0];
  assign ev.x = pos_x;
  assign ev.y = pos_y;

endmodule

// ----- tb/touch_edge_gesture_recognizer_top_tb.sv -----
module touch_edge_gesture_recognizer_top_tb;
  import tegr_pkg::*;

  localparam int DRAG_THRESH  = 8;
  localparam int FLICK_THRESH = 20;
  localparam int HOLD_CYCLES  = 400;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 140;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic [InDataW-1:0]   in_tdata = '0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [OutDataW-1:0]  out_tdata;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CfgIdxW-1:0]   cfg_index = '0;
  logic [CfgDataW-1:0]  cfg_data = '0;

  // samples waiting to be sent and events waiting to come back
  logic [InDataW-1:0] pending_samples[$];
  event_t             expected_events[$];

  // gesture tracker mirror
  logic         touching = 1'b0;
  logic [2:0]   gkind = G_NONE;
  coord_t       start_x = '0;
  coord_t       start_y = '0;

  // threshold registers as last written
  int scr_w = 240;
  int scr_h = 240;
  int zone = 28;
  int back_commit = 42;
  int back_cancel = -18;
  int back_dy = 120;
  int vert_commit = 42;
  int horiz_commit = 42;

  int send_pct = 0;
  int recv_pct = 0;
  int hold_asked = 0;
  int hold_given = 0;
  int hold_left = 0;
  int errors = 0;
  int cycles = 0;

  touch_edge_gesture_recognizer_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #1 clk = ~clk;

  function automatic int mag(input int v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic coord_t clip(input int v);
    if (v < 0) return '0;
    if (v > 2047) return 11'd2047;
    return coord_t'(v);
  endfunction

  // bits: contact [0], pos_x [11:1], pos_y [22:12], zero [23]
  function automatic logic [InDataW-1:0] pack_sample(input logic c, input coord_t x,
                                                     input coord_t y);
    return {1'b0, y, x, c};
  endfunction

  function automatic void push_event(input logic [CodeW-1:0] code, input int amount,
                                     input coord_t x, input coord_t y);
    event_t ev;
    int     sat;
    sat = (amount > 2047) ? 2047 : ((amount < -2048) ? -2048 : amount);
    ev.code = code;
    ev.amount = sat[AmountW-1:0];
    ev.x = x;
    ev.y = y;
    expected_events.push_back(ev);
  endfunction

  // edge zone of a touch-down point, in priority order
  function automatic logic [2:0] zone_of(input coord_t x, input coord_t y);
    int sx, sy;
    sx = int'(x);
    sy = int'(y);
    if (sx <= zone) return G_BACK;
    if (sy >= scr_h - zone) return G_BOTTOM;
    if (sy <= zone) return G_TOP;
    if (sx >= scr_w - zone) return G_RIGHT;
    return G_SCROLL;
  endfunction

  // commit rules applied when the finger lifts
  function automatic void lift_event(input coord_t x, input coord_t y, input int dx,
                                     input int dy);
    int adx, ady;
    adx = mag(dx);
    ady = mag(dy);
    case (gkind)
      G_BACK: begin
        if (dx >= back_commit && ady <= back_dy && 2 * dx >= ady)
          push_event(EV_BACK_COMMIT, (dx < 0) ? 0 : dx, x, y);
        else
          push_event(EV_BACK_CANCEL, 0, x, y);
      end
      G_BOTTOM: begin
        if (-dy >= vert_commit && -2 * dy >= adx) push_event(EV_BOTTOM, -dy, x, y);
      end
      G_TOP: begin
        if (dy >= vert_commit && 2 * dy >= adx) push_event(EV_TOP, dy, x, y);
      end
      G_RIGHT: begin
        if (-dx >= horiz_commit && -2 * dx >= ady) push_event(EV_RIGHT, -dx, x, y);
      end
      G_SCROLL: begin
        if (dx >= horiz_commit && dx > ady)
          push_event(EV_SWIPE_RIGHT, dx, x, y);
        else if (-dx >= horiz_commit && -dx > ady)
          push_event(EV_SWIPE_LEFT, -dx, x, y);
        else if (ady >= FLICK_THRESH && ady > adx)
          push_event(EV_FLICK, dy, x, y);
      end
      default: ;
    endcase
  endfunction

  // advance the tracker by one sample and queue the event it causes
  function automatic void track_sample(input logic contact, input coord_t x,
                                       input coord_t y);
    int dx, dy;
    dx = int'(x) - int'(start_x);
    dy = int'(y) - int'(start_y);
    if (contact && !touching) begin
      touching = 1'b1;
      start_x = x;
      start_y = y;
      gkind = zone_of(x, y);
      push_event(EV_ACTIVITY, 0, x, y);
    end else if (contact) begin
      if (gkind == G_BACK) begin
        if (dx <= back_cancel) begin
          gkind = G_NONE;
          push_event(EV_BACK_CANCEL, 0, x, y);
        end else begin
          push_event(EV_BACK_PROGRESS, (dx < 0) ? 0 : dx, x, y);
        end
      end else if (gkind == G_SCROLL && mag(dy) >= DRAG_THRESH && mag(dy) >= mag(dx)) begin
        push_event(EV_DRAG, dy, x, y);
      end
    end else if (touching) begin
      lift_event(x, y, dx, dy);
      touching = 1'b0;
      gkind = G_NONE;
    end
  endfunction

  // sample driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) track_sample(in_tdata[0], in_tdata[11:1], in_tdata[22:12]);
      if (!in_tvalid || in_tready) begin
        if (pending_samples.size() != 0 && $urandom_range(0, 99) >= send_pct) begin
          in_tdata <= pending_samples.pop_front();
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, armed from the sequence
  always @(posedge clk) begin
    if (hold_asked != hold_given) begin
      hold_given <= hold_asked;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // event monitor and checker
  always @(posedge clk) begin
    event_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_events.size() == 0) begin
        $error("event word with nothing expected: %h", out_tdata);
        errors++;
      end else begin
        want = expected_events.pop_front();
        if (out_tdata[3:0] !== want.code) begin
          $error("event_code: expected %0d, got %0d", want.code, out_tdata[3:0]);
          errors++;
        end
        if (out_tdata[15:4] !== want.amount) begin
          $error("amount: expected %0d, got %0d", $signed(want.amount),
                 $signed(out_tdata[15:4]));
          errors++;
        end
        if (out_tdata[26:16] !== want.x) begin
          $error("event_x: expected %0d, got %0d", want.x, out_tdata[26:16]);
          errors++;
        end
        if (out_tdata[37:27] !== want.y) begin
          $error("event_y: expected %0d, got %0d", want.y, out_tdata[37:27]);
          errors++;
        end
      end
    end
    out_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_pct);
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("touch_edge_gesture_recognizer_top_tb: errors");
      $finish;
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int val);
    logic [11:0] v;
    v = val[11:0];
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_SCREEN_WIDTH:  scr_w = int'(v);
      CFG_SCREEN_HEIGHT: scr_h = int'(v);
      CFG_EDGE_ZONE:     zone = int'(v[7:0]);
      CFG_BACK_COMMIT:   back_commit = int'(v[10:0]);
      CFG_BACK_CANCEL:   back_cancel = int'($signed(v));
      CFG_BACK_MAX_DY:   back_dy = int'(v[10:0]);
      CFG_VERT_COMMIT:   vert_commit = int'(v[10:0]);
      CFG_HORIZ_COMMIT:  horiz_commit = int'(v[10:0]);
      default: ;
    endcase
  endtask

  task automatic set_thresholds(input int w, input int h, input int e, input int bc,
                                input int bk, input int md, input int vc, input int hc);
    write_reg(CFG_SCREEN_WIDTH, w);
    write_reg(CFG_SCREEN_HEIGHT, h);
    write_reg(CFG_EDGE_ZONE, e);
    write_reg(CFG_BACK_COMMIT, bc);
    write_reg(CFG_BACK_CANCEL, bk);
    write_reg(CFG_BACK_MAX_DY, md);
    write_reg(CFG_VERT_COMMIT, vc);
    write_reg(CFG_HORIZ_COMMIT, hc);
  endtask

  // everything sent, every event back, and the pipe flushed of silent samples
  task automatic wait_quiet();
    do @(negedge clk);
    while (pending_samples.size() != 0 || in_tvalid || expected_events.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  function automatic void put_sample(input logic c, input int x, input int y);
    pending_samples.push_back(pack_sample(c, clip(x), clip(y)));
  endfunction

  // travel biased toward the current commit and cancel thresholds
  function automatic int pick_delta();
    int m;
    case ($urandom_range(0, 5))
      0: m = $urandom_range(0, 25);
      1: m = horiz_commit + int'($urandom_range(0, 4)) - 2;
      2: m = vert_commit + int'($urandom_range(0, 4)) - 2;
      3: m = back_commit + int'($urandom_range(0, 4)) - 2;
      4: m = mag(back_cancel) + int'($urandom_range(0, 4)) - 2;
      default: m = $urandom_range(0, 2047);
    endcase
    return $urandom_range(0, 1) ? m : -m;
  endfunction

  // touch-down in a chosen zone, a few held moves, then lift; returns samples queued
  function automatic int queue_gesture();
    int x0, y0, dx, dy, holds;
    x0 = $urandom_range(0, 2047);
    y0 = $urandom_range(0, 2047);
    case ($urandom_range(0, 4))
      0: x0 = $urandom_range(0, (zone > 2047) ? 2047 : zone);
      1: y0 = scr_h - zone + int'($urandom_range(0, 40));
      2: y0 = $urandom_range(0, (zone > 2047) ? 2047 : zone);
      3: x0 = scr_w - zone + int'($urandom_range(0, 40));
      default: begin
        x0 = scr_w / 2 + int'($urandom_range(0, 120)) - 60;
        y0 = scr_h / 2 + int'($urandom_range(0, 120)) - 60;
      end
    endcase
    x0 = int'(clip(x0));
    y0 = int'(clip(y0));
    dx = pick_delta();
    dy = pick_delta();
    holds = $urandom_range(0, 5);
    put_sample(1'b1, x0, y0);
    for (int k = 1; k <= holds; k++)
      put_sample(1'b1, x0 + dx * k / (holds + 1) + int'($urandom_range(0, 6)) - 3,
                 y0 + dy * k / (holds + 1) + int'($urandom_range(0, 6)) - 3);
    put_sample(1'b0, x0 + dx, y0 + dy);
    return holds + 2;
  endfunction

  task automatic queue_random(input int count);
    int n;
    n = 0;
    while (n < count) begin
      if ($urandom_range(0, 99) < 12) begin
        put_sample(1'($urandom_range(0, 1)), $urandom_range(0, 2047),
                   $urandom_range(0, 2047));
        n++;
      end else begin
        n += queue_gesture();
      end
    end
  endtask

  task automatic set_idle(input int phase);
    case (phase % 4)
      0: begin send_pct = 0;  recv_pct = 0;  end
      1: begin send_pct = 63; recv_pct = 0;  end
      2: begin send_pct = 0;  recv_pct = 63; end
      default: begin send_pct = 30; recv_pct = 30; end
    endcase
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed pass at reset thresholds
    put_sample(1'b0, 2047, 2047);   // lift with no touch in progress
    put_sample(1'b1, 0, 0);         // back gesture from the corner
    put_sample(1'b1, 30, 5);
    put_sample(1'b1, 0, 5);         // progress clamps at zero
    put_sample(1'b0, 60, 10);       // back commit
    put_sample(1'b1, 28, 100);      // zone boundary still counts as back
    put_sample(1'b1, 10, 100);      // cancel while held
    put_sample(1'b1, 200, 100);     // cancelled touch stays silent
    put_sample(1'b0, 200, 100);
    put_sample(1'b1, 5, 100);
    put_sample(1'b0, 20, 100);      // back not far enough: cancel on lift
    put_sample(1'b1, 120, 230);
    put_sample(1'b0, 120, 150);     // bottom swipe
    put_sample(1'b1, 120, 10);
    put_sample(1'b0, 130, 100);     // top swipe
    put_sample(1'b1, 230, 120);
    put_sample(1'b0, 100, 120);     // right edge swipe
    put_sample(1'b1, 120, 120);
    put_sample(1'b1, 120, 140);     // drag
    put_sample(1'b0, 200, 120);     // swipe right
    put_sample(1'b1, 120, 120);
    put_sample(1'b0, 40, 120);      // swipe left
    put_sample(1'b1, 120, 120);
    put_sample(1'b0, 125, 150);     // flick
    put_sample(1'b1, 2047, 2047);
    put_sample(1'b0, 0, 0);         // largest travel
    put_sample(1'b1, 2047, 0);
    put_sample(1'b0, 0, 2047);

    for (int phase = 0; phase < 6; phase++) begin
      if (phase != 0) begin
        wait_quiet();
        case (phase)
          1: set_thresholds(1, 1, 0, 0, -2048, 0, 0, 0);
          2: set_thresholds(2048, 2048, 255, 2047, 0, 2047, 2047, 2047);
          3: set_thresholds($urandom_range(1, 2048), $urandom_range(1, 2048),
                            $urandom_range(0, 255), $urandom_range(0, 2047),
                            -int'($urandom_range(0, 2048)), $urandom_range(0, 2047),
                            $urandom_range(0, 2047), $urandom_range(0, 2047));
          4: set_thresholds($urandom_range(0, 4095), $urandom_range(0, 4095),
                            $urandom_range(0, 4095), $urandom_range(0, 4095),
                            $urandom_range(0, 4095), $urandom_range(0, 4095),
                            $urandom_range(0, 4095), $urandom_range(0, 4095));
          default: set_thresholds($urandom_range(120, 480), $urandom_range(120, 480),
                                  $urandom_range(0, 60), $urandom_range(0, 100),
                                  -int'($urandom_range(0, 60)), $urandom_range(0, 300),
                                  $urandom_range(0, 100), $urandom_range(0, 100));
        endcase
        @(negedge clk);
      end
      set_idle(phase);
      // receiver holds off while the sender keeps pushing
      if (phase == 4) hold_asked = hold_asked + 1;
      queue_random(RANDOM_ITEMS);
    end

    wait_quiet();
    if (errors == 0) begin
      $display("touch_edge_gesture_recognizer_top_tb: clean");
    end else begin
      $display("touch_edge_gesture_recognizer_top_tb: errors");
    end
    $finish;
  end

endmodule
